[hdl/stsc_pkg.sv]
package stsc_pkg;

    // Sequence and table sizing
    localparam int MAX_LEN      = 1024;
    localparam int TABLE_DEPTH  = 2048;   // power of two: home slot is the low key bits
    localparam int SAMPLE_WIDTH = 16;     // bits of the sample used as a signed value

    // Field and state widths
    localparam int SAMPLE_IN_W  = 16;
    localparam int PREFIX_W     = 26;
    localparam int TARGET_W     = 27;
    localparam int TOTAL_W      = 20;
    localparam int TALLY_W      = 11;
    localparam int TAG_W        = 8;      // sequence epoch stored with each entry
    localparam int OUT_DATA_W   = 24;
    localparam int SLOT_W       = $clog2(TABLE_DEPTH);
    localparam int ITEMS_W      = $clog2(MAX_LEN + 1);

    // One table slot; the entry is live only when tag equals the current epoch
    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [TALLY_W-1:0]  tally;
        logic [PREFIX_W-1:0] key;
    } t_entry;

    // Search result handed from the probe unit to the sequencer
    typedef struct packed {
        logic done;
        logic hit;
        logic full;
    } t_probe_rsp;

    // Home slot of a key: its low 11 bits, which is the key modulo the table depth
    function automatic logic [SLOT_W-1:0] home_slot(input logic [PREFIX_W-1:0] key);
        return key[SLOT_W-1:0];
    endfunction

endpackage

[hdl/stsc_table.sv]
module stsc_table (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [stsc_pkg::SLOT_W-1:0] i_waddr,
    input  stsc_pkg::t_entry            i_wdata,
    input  logic [stsc_pkg::SLOT_W-1:0] i_raddr,
    output stsc_pkg::t_entry            o_rdata
);
    import stsc_pkg::*;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    // Single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/stsc_probe.sv]
module stsc_probe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [stsc_pkg::PREFIX_W-1:0] i_key,
    input  logic [stsc_pkg::TAG_W-1:0]    i_epoch,
    input  stsc_pkg::t_entry              i_rd_entry,
    output logic [stsc_pkg::SLOT_W-1:0]   o_rd_addr,
    output logic [stsc_pkg::SLOT_W-1:0]   o_slot,
    output logic [stsc_pkg::TALLY_W-1:0]  o_tally,
    output stsc_pkg::t_probe_rsp          o_rsp
);
    import stsc_pkg::*;

    logic                r_busy, n_busy;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [SLOT_W-1:0]   r_cnt, n_cnt;
    logic [PREFIX_W-1:0] r_key;
    logic [TALLY_W-1:0]  r_tally;
    t_probe_rsp          r_rsp, n_rsp;

    logic w_free, w_match, w_last_try;

    // Read data always belongs to r_slot: the address issued is the next slot
    assign w_free     = (i_rd_entry.tag != i_epoch);
    assign w_match    = !w_free && (i_rd_entry.key == r_key);
    assign w_last_try = (r_cnt == SLOT_W'(TABLE_DEPTH - 1));

    // Linear probe: one slot checked per cycle
    always_comb begin
        n_busy = r_busy;
        n_slot = r_slot;
        n_cnt  = r_cnt;
        n_rsp  = '0;
        if (i_start) begin
            n_busy = 1'b1;
            n_slot = home_slot(i_key);
            n_cnt  = '0;
        end else if (r_busy) begin
            if (w_free || w_match || w_last_try) begin
                n_busy     = 1'b0;
                n_rsp.done = 1'b1;
                n_rsp.hit  = w_match;
                n_rsp.full = !w_free && !w_match;
            end else begin
                // wraps at the table end since the depth is a power of two
                n_slot = r_slot + 1'b1;
                n_cnt  = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= '0;
            r_cnt  <= '0;
            r_rsp  <= '0;
        end else begin
            r_busy <= n_busy;
            r_slot <= n_slot;
            r_cnt  <= n_cnt;
            r_rsp  <= n_rsp;
        end
    end

    // Search key and tally of the slot last checked
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
        end
        if (r_busy) begin
            r_tally <= i_rd_entry.tally;
        end
    end

    assign o_rd_addr = n_slot;
    assign o_slot    = r_slot;
    assign o_tally   = r_tally;
    assign o_rsp     = r_rsp;

endmodule

[hdl/subarray_target_sum_counter.sv]
// Counts contiguous runs of a signed sample stream whose sum equals target_sum.
// Each accepted sample gives one result with the running match count; the item
// marked tlast gives a result with tlast set and then starts a new sequence.
// Samples past the 1024th of a sequence are ignored and flagged in tuser.
// Prefix-sum tallies live in one 2048-slot hash table with linear probing,
// searched one slot per cycle by a single probe unit that is used twice per
// sample (lookup of prefix minus target, then update of the new prefix),
// except that a lookup key outside the 26-bit prefix range skips the lookup.
// Every extra slot either search has to step past lengthens a sample, and
// the output state waits for the previous result to be taken; an ignored
// sample skips both searches. Closing a sequence reseeds the table, and
// every 255th sequence a pass over all 2048 slots rewrites them. The same
// pass runs after reset before the first sample is accepted; target_sum
// writes are taken at any time.
module subarray_target_sum_counter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration: target_sum
    input  logic                             i_cfg_we,
    input  logic [stsc_pkg::TARGET_W-1:0]    i_cfg_wdata,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [stsc_pkg::SAMPLE_IN_W-1:0] s_axis_tdata,   // [15:0] sample
    input  logic                             s_axis_tlast,   // last_sample
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [stsc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // [19:0] matching_runs
    output logic                             m_axis_tlast,   // final_result
    output logic                             m_axis_tuser    // [0] status
);
    import stsc_pkg::*;

    // Sequencer states
    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_SEED = 4'd1;
    localparam logic [3:0] ST_IDLE = 4'd2;
    localparam logic [3:0] ST_WANT = 4'd3;
    localparam logic [3:0] ST_LOOK = 4'd4;
    localparam logic [3:0] ST_ADD  = 4'd5;
    localparam logic [3:0] ST_INS  = 4'd6;
    localparam logic [3:0] ST_OUT  = 4'd7;

    logic [3:0]          r_state, n_state;
    logic [SLOT_W-1:0]   r_clr, n_clr;
    logic [TAG_W-1:0]    r_epoch, n_epoch;
    logic [TARGET_W-1:0] r_target;
    logic [PREFIX_W-1:0] r_prefix, n_prefix;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [ITEMS_W-1:0]  r_items, n_items;
    logic                r_last, n_last;
    logic                r_status, n_status;
    logic                r_m_valid, n_m_valid;
    logic [TOTAL_W-1:0]  r_m_total, n_m_total;
    logic                r_m_last, n_m_last;
    logic                r_m_status, n_m_status;

    logic                w_accept;
    logic [PREFIX_W-1:0] w_sample_ext;
    logic [TARGET_W:0]   w_want;
    logic                w_want_ok;
    logic [TOTAL_W:0]    w_sum;
    logic [TALLY_W-1:0]  w_tally_inc;

    logic                w_we;
    logic [SLOT_W-1:0]   w_waddr;
    t_entry              w_wdata;
    t_entry              w_rdata;

    logic                w_pr_start;
    logic [PREFIX_W-1:0] w_pr_key;
    logic [SLOT_W-1:0]   w_pr_raddr;
    logic [SLOT_W-1:0]   w_pr_slot;
    logic [TALLY_W-1:0]  w_pr_tally;
    t_probe_rsp          w_rsp;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Sample sign-extended to the prefix width
    assign w_sample_ext = {{(PREFIX_W - SAMPLE_WIDTH){s_axis_tdata[SAMPLE_WIDTH-1]}},
                           s_axis_tdata[SAMPLE_WIDTH-1:0]};

    // Lookup key; it must fit the signed prefix range to be found at all
    assign w_want    = {{(TARGET_W + 1 - PREFIX_W){r_prefix[PREFIX_W-1]}}, r_prefix}
                     - {r_target[TARGET_W-1], r_target};
    assign w_want_ok = (w_want[TARGET_W:PREFIX_W-1] == '0)
                    || (w_want[TARGET_W:PREFIX_W-1] == '1);

    // Saturating match total and tally
    assign w_sum       = {1'b0, r_total} + (TOTAL_W + 1)'(w_pr_tally);
    assign w_tally_inc = (w_pr_tally == '1) ? w_pr_tally : w_pr_tally + 1'b1;

    // Probe unit: lookup from WANT, update from ADD or an out-of-range WANT
    assign w_pr_start = (r_state == ST_WANT) || (r_state == ST_ADD);
    assign w_pr_key   = ((r_state == ST_WANT) && w_want_ok) ? w_want[PREFIX_W-1:0] : r_prefix;

    stsc_probe u_probe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_pr_start),
        .i_key      (w_pr_key),
        .i_epoch    (r_epoch),
        .i_rd_entry (w_rdata),
        .o_rd_addr  (w_pr_raddr),
        .o_slot     (w_pr_slot),
        .o_tally    (w_pr_tally),
        .o_rsp      (w_rsp)
    );

    stsc_table u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_pr_raddr),
        .o_rdata (w_rdata)
    );

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_epoch    = r_epoch;
        n_prefix   = r_prefix;
        n_total    = r_total;
        n_items    = r_items;
        n_last     = r_last;
        n_status   = r_status;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_total  = r_m_total;
        n_m_last   = r_m_last;
        n_m_status = r_m_status;
        w_we       = 1'b0;
        w_waddr    = r_clr;
        w_wdata    = '0;

        unique case (r_state)
            ST_CLR: begin
                // tag zero is never a live epoch
                w_we  = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == SLOT_W'(TABLE_DEPTH - 1)) begin
                    n_epoch = TAG_W'(1);
                    n_state = ST_SEED;
                end
            end
            ST_SEED: begin
                // prefix zero seen once
                w_we          = 1'b1;
                w_waddr       = home_slot('0);
                w_wdata.tag   = r_epoch;
                w_wdata.tally = TALLY_W'(1);
                w_wdata.key   = '0;
                n_state       = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_last = s_axis_tlast;
                    if (r_items >= ITEMS_W'(MAX_LEN)) begin
                        n_status = 1'b1;
                        n_state  = ST_OUT;
                    end else begin
                        n_status = 1'b0;
                        n_prefix = r_prefix + w_sample_ext;
                        n_items  = r_items + 1'b1;
                        n_state  = ST_WANT;
                    end
                end
            end
            ST_WANT: begin
                n_state = w_want_ok ? ST_LOOK : ST_INS;
            end
            ST_LOOK: begin
                if (w_rsp.done) begin
                    if (w_rsp.hit) begin
                        n_total = (w_sum > {1'b0, {TOTAL_W{1'b1}}}) ? {TOTAL_W{1'b1}}
                                                                    : w_sum[TOTAL_W-1:0];
                    end
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_state = ST_INS;
            end
            ST_INS: begin
                if (w_rsp.done) begin
                    // a full table drops the insertion
                    w_we          = !w_rsp.full;
                    w_waddr       = w_pr_slot;
                    w_wdata.tag   = r_epoch;
                    w_wdata.tally = w_rsp.hit ? w_tally_inc : TALLY_W'(1);
                    w_wdata.key   = r_prefix;
                    n_state       = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_total  = r_total;
                    n_m_last   = r_last;
                    n_m_status = r_status;
                    if (r_last) begin
                        // new sequence: retire the epoch, sweep when it wraps
                        n_prefix = '0;
                        n_total  = '0;
                        n_items  = '0;
                        n_epoch  = r_epoch + 1'b1;
                        n_clr    = '0;
                        n_state  = (n_epoch == '0) ? ST_CLR : ST_SEED;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_CLR;
                n_clr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_clr     <= '0;
            r_epoch   <= TAG_W'(1);
            r_prefix  <= '0;
            r_total   <= '0;
            r_items   <= '0;
            r_last    <= 1'b0;
            r_status  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_epoch   <= n_epoch;
            r_prefix  <= n_prefix;
            r_total   <= n_total;
            r_items   <= n_items;
            r_last    <= n_last;
            r_status  <= n_status;
            r_m_valid <= n_m_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_m_total  <= n_m_total;
        r_m_last   <= n_m_last;
        r_m_status <= n_m_status;
    end

    // Target register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_we) begin
            r_target <= i_cfg_wdata;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_m_total);
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = r_m_status;

    // A search only finishes while the sequencer waits for it
    a_probe_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == ST_LOOK || r_state == ST_INS))
        else $error("probe finished outside a search state");

    // A new result appears only after the output state
    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_OUT))
        else $error("result raised outside the output state");

    // The match total never falls within a sequence
    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_OUT) |=> (r_total >= $past(r_total)))
        else $error("match total decreased within a sequence");

endmodule
